[rtl/assert_macros.svh]
// Assertion helpers for the state confirmation block.
// In synthesis builds each macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset.
`define SCMH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("state confirmation assertion failed");

// Property that spans a clock edge.
`define SCMH_ASSERT_SEQ(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("state confirmation sequence check failed");

`else

`define SCMH_ASSERT(label, clk, rst_n, prop)
`define SCMH_ASSERT_SEQ(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/scmh_pkg.sv]
`default_nettype none

package scmh_pkg;

    // Field and counter widths.
    localparam int STATE_BITS = 8;
    localparam int CODE_W     = STATE_BITS + 1;
    localparam int COUNT_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int TDATA_W    = ((CODE_W + 7) / 8) * 8;

    typedef logic signed [CODE_W-1:0] t_code;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [CFG_W-1:0]         t_cfg_word;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;
    typedef logic [TDATA_W-1:0]       t_tdata;

    // Code for "no state" / unknown observation.
    localparam t_code  CODE_NONE = '1;
    localparam t_count COUNT_MAX = '1;
    localparam t_count COUNT_ONE = t_count'(1);

    // Configuration register indexes.
    localparam t_cfg_idx REG_CONFIRM_COUNT = t_cfg_idx'(0);
    localparam t_cfg_idx REG_HOLD_LIMIT    = t_cfg_idx'(1);

    typedef struct packed {
        t_cfg_word confirm_count;
        t_cfg_word hold_limit;
    } t_cfg;

    typedef struct packed {
        t_code  active_state;
        t_code  pending_state;
        t_count pending_run;
        t_count hold_time;
    } t_state;

    // Saturating increment of a counter.
    function automatic t_count count_up(input t_count c);
        count_up = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_ONE;
    endfunction

endpackage

`default_nettype wire

[rtl/scmh_cfg.sv]
`default_nettype none

module scmh_cfg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire scmh_pkg::t_cfg_idx  i_cfg_index,
    input  wire scmh_pkg::t_cfg_word i_cfg_data,
    output scmh_pkg::t_cfg       o_cfg
);
    import scmh_pkg::*;

    t_cfg r_cfg;

    // A configuration word is taken in every cycle.
    assign o_cfg_ready = 1'b1;

    // Register file with reset values of one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_count <= t_cfg_word'(1);
            r_cfg.hold_limit    <= t_cfg_word'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CONFIRM_COUNT: r_cfg.confirm_count <= i_cfg_data;
                REG_HOLD_LIMIT:    r_cfg.hold_limit    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/scmh_update.sv]
`default_nettype none

module scmh_update (
    input  wire scmh_pkg::t_state i_state,
    input  wire scmh_pkg::t_cfg   i_cfg,
    input  wire scmh_pkg::t_code  i_obs,
    output scmh_pkg::t_state      o_state,
    output scmh_pkg::t_code       o_shown
);
    import scmh_pkg::*;

    logic   active_valid;
    logic   obs_unknown;
    t_count hold_inc;
    t_count run_next;
    logic   run_done;
    logic   hold_done;

    assign active_valid = !i_state.active_state[CODE_W-1];
    assign obs_unknown  = i_obs[CODE_W-1];

    // The hold timer advances at the start of every word while a state is active.
    assign hold_inc = active_valid ? count_up(i_state.hold_time) : i_state.hold_time;

    // Run length of the candidate if this word extends or restarts it.
    assign run_next  = (i_obs == i_state.pending_state) ? count_up(i_state.pending_run)
                                                        : COUNT_ONE;
    assign run_done  = (run_next >= i_cfg.confirm_count);
    assign hold_done = (hold_inc > i_cfg.hold_limit);

    always_comb begin
        o_state           = i_state;
        o_state.hold_time = hold_inc;
        o_shown           = CODE_NONE;
        priority if (obs_unknown) begin
            // Unknown observation drops the candidate, active state is kept.
            o_state.pending_state = CODE_NONE;
            o_state.pending_run   = '0;
            o_shown               = CODE_NONE;
        end else if (!active_valid) begin
            // First adoption needs only the confirmation run.
            o_state.pending_state = i_obs;
            o_state.pending_run   = run_next;
            if (run_done) begin
                o_state.active_state = i_obs;
                o_state.hold_time    = COUNT_ONE;
            end
            o_shown = run_done ? i_obs : CODE_NONE;
        end else if (i_obs == i_state.active_state) begin
            o_state.pending_state = CODE_NONE;
            o_state.pending_run   = '0;
            o_shown               = i_state.active_state;
        end else begin
            // A switch needs both the run and the minimum hold.
            o_state.pending_state = i_obs;
            o_state.pending_run   = run_next;
            o_shown               = i_state.active_state;
            if (run_done && hold_done) begin
                o_state.active_state  = i_obs;
                o_state.hold_time     = COUNT_ONE;
                o_state.pending_state = CODE_NONE;
                o_state.pending_run   = '0;
                o_shown               = i_obs;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/state_confirm_min_hold_core.sv]
`default_nettype none

// Debounced state confirmation with a minimum hold. Each input word carries one
// observed state code (0 to 255, any negative code means unknown) and yields one
// output word with the confirmed active state, or -1 when no state has been
// adopted yet or the observation is unknown. A candidate is adopted after
// confirm_count identical words in a row; once a state is active, a switch also
// needs the active state to have lasted more than the hold limit (register 1).
// The block takes one word per clock while the output side is ready: the state
// update is a single compare-and-count pass between the state registers and the
// output register, so each result is presented in the cycle after its word is
// taken. Configuration words are accepted at any time but must only be written
// idle.

`include "assert_macros.svh"

module state_confirm_min_hold_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Configuration write channel.
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire scmh_pkg::t_cfg_idx  i_cfg_index,
    input  wire scmh_pkg::t_cfg_word i_cfg_data,
    // Input stream.
    input  wire                      s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire scmh_pkg::t_tdata    s_axis_tdata,  // [8:0] observed_state, rest zero
    // Output stream.
    output logic                     m_axis_tvalid,
    input  wire                      m_axis_tready,
    output scmh_pkg::t_tdata         m_axis_tdata   // [8:0] state_out, rest zero
);
    import scmh_pkg::*;

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;
    t_code  shown;
    t_code  r_out;
    logic   r_out_valid;
    logic   in_fire;

    scmh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    scmh_update u_update (
        .i_state (r_state),
        .i_cfg   (cfg),
        .i_obs   (t_code'(s_axis_tdata[CODE_W-1:0])),
        .o_state (n_state),
        .o_shown (shown)
    );

    // Accept a new word whenever the output register is free or being drained.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active_state  <= CODE_NONE;
            r_state.pending_state <= CODE_NONE;
            r_state.pending_run   <= '0;
            r_state.hold_time     <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= shown;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = t_tdata'($unsigned(r_out));

    // An active state always has a running hold timer.
    `SCMH_ASSERT(a_hold_nonzero, i_clk, i_rst_n,
        r_state.active_state[CODE_W-1] || (r_state.hold_time != '0))
    // A cleared candidate has no run, a live candidate has one.
    `SCMH_ASSERT(a_run_matches_pending, i_clk, i_rst_n,
        r_state.pending_state[CODE_W-1] == (r_state.pending_run == '0))
    // Once adopted, an active state is never dropped outside reset.
    `SCMH_ASSERT_SEQ(a_active_sticky, i_clk, i_rst_n,
        !$past(r_state.active_state[CODE_W-1]), !r_state.active_state[CODE_W-1])

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import scmh_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_GAP   = 4;
    localparam int HOLD_OFF    = 300;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        t_cfg_idx  idx;
        t_cfg_word value;
        t_code     obs;
        logic      typed;
        t_code     want;
    } t_row;

    // Directed plan. Register rows are written with the block idle; typed rows carry
    // the state_out that is plain from the row itself, the rest use the predictor.
    localparam t_row PLAN [0:25] = '{
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     CODE_NONE,  1'b1, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h000,     1'b1, 9'h000},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h0FF,     1'b1, 9'h0FF},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h100,     1'b1, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h0FF,     1'b1, 9'h0FF},
        '{ROW_REG,  REG_CONFIRM_COUNT, 16'd0,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_REG,  REG_HOLD_LIMIT,    16'd0,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h007,     1'b1, 9'h007},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h008,     1'b1, 9'h008},
        '{ROW_REG,  REG_CONFIRM_COUNT, 16'd3,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_REG,  REG_HOLD_LIMIT,    16'd4,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h009,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h1AA,     1'b1, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h009,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h009,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h009,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h009,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h0AA,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h155,     1'b1, CODE_NONE},
        '{ROW_REG,  REG_CONFIRM_COUNT, 16'd1,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_REG,  REG_HOLD_LIMIT,    16'hFFFF,  CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h00A,     1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h00B,     1'b0, CODE_NONE},
        '{ROW_REG,  REG_CONFIRM_COUNT, 16'hFFFF,  CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_REG,  REG_HOLD_LIMIT,    16'd1,     CODE_NONE,  1'b0, CODE_NONE},
        '{ROW_WORD, REG_CONFIRM_COUNT, 16'd0,     9'h00C,     1'b0, CODE_NONE}
    };

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = '0;
    t_cfg_word  i_cfg_data = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    t_tdata     s_axis_tdata = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    t_tdata     m_axis_tdata;

    // Predictor copy of the registers and the tracking state.
    t_cfg_word  pred_confirm = 16'd1;
    t_cfg_word  pred_hold_limit = 16'd1;
    t_code      pred_active = CODE_NONE;
    t_code      pred_pending = CODE_NONE;
    t_count     pred_run = '0;
    t_count     pred_hold = '0;

    t_code      state_out_q [$];
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    bit         hold_req = 1'b0;
    int         hold_left = 0;
    int         cycle_cnt = 0;
    int         n_words = 0;
    int         n_checked = 0;
    int         n_reg_writes = 0;
    int         n_fail = 0;

    state_confirm_min_hold_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [8:0] observed_state, rest zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)     // [8:0] state_out, rest zero
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     state_out_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic t_tdata pack_code(input t_code c);
        t_tdata w;
        w = '0;
        w[CODE_W-1:0] = c;
        return w;
    endfunction

    // Advance the tracking state by one observation and return the shown state.
    function automatic t_code confirm_step(input t_code obs);
        t_code shown;
        if (!pred_active[CODE_W-1]) pred_hold = sat_inc(pred_hold);
        if (obs[CODE_W-1]) begin
            // Unknown observation: drop the candidate, show no state.
            pred_pending = CODE_NONE;
            pred_run = '0;
            shown = CODE_NONE;
        end else begin
            if (pred_active[CODE_W-1]) begin
                // First adoption ignores the hold.
                pred_run = (obs == pred_pending) ? sat_inc(pred_run) : t_count'(1);
                pred_pending = obs;
                if (pred_run >= pred_confirm) begin
                    pred_active = pred_pending;
                    pred_hold = t_count'(1);
                end
            end else if (obs == pred_active) begin
                pred_pending = CODE_NONE;
                pred_run = '0;
            end else begin
                pred_run = (obs == pred_pending) ? sat_inc(pred_run) : t_count'(1);
                pred_pending = obs;
                if (pred_run >= pred_confirm && pred_hold > pred_hold_limit) begin
                    pred_active = pred_pending;
                    pred_hold = t_count'(1);
                    pred_pending = CODE_NONE;
                    pred_run = '0;
                end
            end
            shown = pred_active;
        end
        return shown;
    endfunction

    // Receiver side: random stalls plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF;
            hold_req = 1'b0;
        end
        if (hold_left > 0) hold_left--;
        m_axis_tready = (hold_left == 0) &&
                        !(sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct);
    end

    // Output checker: every accepted word is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_code want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (state_out_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("Unexpected output word %h at cycle %0d", m_axis_tdata, cycle_cnt);
            end else begin
                want = state_out_q.pop_front();
                n_checked++;
                if (m_axis_tdata !== pack_code(want)) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("state_out mismatch at cycle %0d: expected %h, got %h",
                                 cycle_cnt, pack_code(want), m_axis_tdata);
                end
            end
        end
    end

    // Offer one observation word, after a random idle gap, and record its result.
    task automatic send_obs(input t_code obs, input logic typed, input t_code want);
        t_code shown;
        @(negedge i_clk);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = pack_code(obs);
        do @(posedge i_clk); while (!s_axis_tready);
        shown = confirm_step(obs);
        state_out_q.push_back(typed ? want : shown);
        n_words++;
    endtask

    // Stop offering and wait until every expected word has come out.
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (state_out_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_word value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_CONFIRM_COUNT) pred_confirm = value;
        else if (idx == REG_HOLD_LIMIT) pred_hold_limit = value;
        n_reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Pick a setting, with the extremes now and then, and write both registers.
    task automatic random_settings();
        int r;
        t_cfg_word confirm;
        t_cfg_word hold_lim;
        r = $urandom_range(9);
        confirm = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : t_cfg_word'($urandom_range(1, 5));
        r = $urandom_range(9);
        hold_lim = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFE : (r == 2) ? 16'hFFFF :
                   t_cfg_word'($urandom_range(1, 8));
        drain_results();
        write_reg(REG_CONFIRM_COUNT, confirm);
        write_reg(REG_HOLD_LIMIT, hold_lim);
    endtask

    // Mostly runs of a few recurring states, mixed with unknown and stray codes.
    task automatic random_traffic(input int n_items, input bit with_hold);
        t_code palette [4];
        t_code obs;
        int    sent;
        int    run_len;
        int    r;
        foreach (palette[k]) palette[k] = t_code'($urandom_range(255));
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 10) begin
                obs = t_code'({1'b1, 8'($urandom)});
                run_len = 1;
            end else if (r < 20) begin
                obs = t_code'($urandom_range(255));
                run_len = 1;
            end else begin
                obs = palette[$urandom_range(3)];
                run_len = $urandom_range(1, 12);
            end
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                send_obs(obs, 1'b0, CODE_NONE);
                sent++;
                if (with_hold && sent == n_items / 2) hold_req = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed plan with the reset settings first.
        foreach (PLAN[i]) begin
            if (PLAN[i].kind == ROW_REG) begin
                drain_results();
                write_reg(PLAN[i].idx, PLAN[i].value);
            end else begin
                send_obs(PLAN[i].obs, PLAN[i].typed, PLAN[i].want);
            end
        end

        // Random phases under each flow-control pattern.
        for (int mode = 0; mode < 4; mode++) begin
            drain_results();
            src_idle_pct   = (mode == 1) ? 58 : (mode == 3) ? 7 : 0;
            sink_stall_pct = (mode == 2) ? 58 : (mode == 3) ? 7 : 0;
            for (int part = 0; part < 2; part++) begin
                random_settings();
                random_traffic(50, mode == 0 && part == 0);
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (state_out_q.size() != 0) n_fail++;
        $display("Covered %0d observation words and %0d register writes: unknown codes,",
                 n_words, n_reg_writes);
        $display("zero and maximal settings, long output stalls; %0d results checked, %0d bad.",
                 n_checked, n_fail);
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/scmh_pkg.sv
rtl/scmh_cfg.sv
rtl/scmh_update.sv
rtl/state_confirm_min_hold_core.sv
tb/tb.sv
